// ===== hw/rtl/line_follow_pid_drive_assert.svh =====
// Assertion macros for the line follower PID drive checker.
// Needs signals named clk and rst_n in the scope of use.
`ifndef LINE_FOLLOW_PID_DRIVE_ASSERT_SVH
`define LINE_FOLLOW_PID_DRIVE_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define LFPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lfpd_pkg.sv =====
// Shared types, widths, register codes and the microcode ROM of the line follower.
// No dependencies; used by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

  localparam int SENSORS = 8;

  // Field widths fixed by the interface
  localparam int SMP_W  = 12;
  localparam int GAIN_W = 16;
  localparam int SPD_W  = 16;
  localparam int MAXA_W = 4;
  localparam int ERR_W  = 11;
  localparam int CNTO_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived datapath widths
  localparam int FRAC_W   = 8;
  localparam int CNT_W    = $clog2(SENSORS + 1);
  localparam int POS_W    = $clog2(SENSORS * (SENSORS + 1) / 2 + 1);
  localparam int DIV_ITER = (POS_W + FRAC_W + 1) / 2;
  localparam int NUM_W    = 2 * DIV_ITER;
  localparam int LOOP_W   = $clog2(DIV_ITER);
  localparam int CENTRE_Q = (SENSORS + 1) * 128;
  localparam int INT_W    = 32;
  localparam int DER_W    = ERR_W + 1;
  localparam int PROD_W   = GAIN_W + 1 + INT_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int GAIN_FRAC = 12;
  localparam int OFF_W    = ACC_W - GAIN_FRAC;
  localparam int SUM_W    = OFF_W + 1;

  typedef logic [SMP_W-1:0] sample_t;

  typedef struct packed {
    logic [SMP_W-1:0]  threshold;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [SPD_W-1:0]  base_speed;
    logic [SPD_W-1:0]  max_speed;
    logic [MAXA_W-1:0] max_active;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold:  SMP_W'(800),
    gain_p:     GAIN_W'(16384),
    gain_i:     GAIN_W'(4),
    gain_d:     GAIN_W'(819),
    base_speed: SPD_W'(2560),
    max_speed:  SPD_W'(5120),
    max_active: MAXA_W'(3)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_GAIN_P     = 3'd1,
    CFG_GAIN_I     = 3'd2,
    CFG_GAIN_D     = 3'd3,
    CFG_BASE_SPEED = 3'd4,
    CFG_MAX_SPEED  = 3'd5,
    CFG_MAX_ACTIVE = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_TAKE     = 4'd1,
    OP_DIV_INIT = 4'd2,
    OP_DIV_STEP = 4'd3,
    OP_ERR      = 4'd4,
    OP_INTEG    = 4'd5,
    OP_MUL_I    = 4'd6,
    OP_MUL_D    = 4'd7,
    OP_ACC      = 4'd8,
    OP_EMIT     = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    J_NONE     = 2'd0,
    J_NO_IN    = 2'd1,
    J_LOOP     = 2'd2,
    J_OUT_BUSY = 2'd3
  } jcond_t;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_TAKE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_DIV  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(8);

  typedef struct packed {
    op_t               op;
    jcond_t            jcond;
    logic [STEP_W-1:0] target;
    logic              last;
  } uword_t;

  // Status from the datapath that the jump conditions test
  typedef struct packed {
    logic in_avail;
    logic loop_last;
    logic out_blocked;
  } stat_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_NOP, jcond: J_NONE, target: STEP_TAKE, last: 1'b1};
    case (step)
      STEP_W'(0): w = '{op: OP_TAKE,     jcond: J_NO_IN,    target: STEP_TAKE, last: 1'b0};
      STEP_W'(1): w = '{op: OP_DIV_INIT, jcond: J_NONE,     target: STEP_TAKE, last: 1'b0};
      STEP_W'(2): w = '{op: OP_DIV_STEP, jcond: J_LOOP,     target: STEP_DIV,  last: 1'b0};
      STEP_W'(3): w = '{op: OP_ERR,      jcond: J_NONE,     target: STEP_TAKE, last: 1'b0};
      STEP_W'(4): w = '{op: OP_INTEG,    jcond: J_NONE,     target: STEP_TAKE, last: 1'b0};
      STEP_W'(5): w = '{op: OP_MUL_I,    jcond: J_NONE,     target: STEP_TAKE, last: 1'b0};
      STEP_W'(6): w = '{op: OP_MUL_D,    jcond: J_NONE,     target: STEP_TAKE, last: 1'b0};
      STEP_W'(7): w = '{op: OP_ACC,      jcond: J_NONE,     target: STEP_TAKE, last: 1'b0};
      STEP_W'(8): w = '{op: OP_EMIT,     jcond: J_OUT_BUSY, target: STEP_EMIT, last: 1'b1};
      default:    w = '{op: OP_NOP,      jcond: J_NONE,     target: STEP_TAKE, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lfpd_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on lfpd_pkg for the ROM, the control word and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  lfpd_pkg::stat_t stat,
  output lfpd_pkg::op_t   op
);
  import lfpd_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  uword_t            uw;
  logic              jump;

  assign uw = ucode_rom(step_r);
  assign op = uw.op;

  always_comb begin
    case (uw.jcond)
      J_NONE:     jump = 1'b0;
      J_NO_IN:    jump = !stat.in_avail;
      J_LOOP:     jump = !stat.loop_last;
      J_OUT_BUSY: jump = stat.out_blocked;
      default:    jump = 1'b0;
    endcase
    if (jump) begin
      step_nxt = uw.target;
    end else if (uw.last) begin
      step_nxt = STEP_TAKE;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_TAKE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfpd_dp.sv =====
// Datapath: sensor threshold, radix-4 centroid divider, shared PID multiplier,
// accumulator, speed clamp and output register. Driven by ops from lfpd_seq.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_dp (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  lfpd_pkg::op_t                               op,
  input  lfpd_pkg::cfg_t                              cfg,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  lfpd_pkg::sample_t [lfpd_pkg::SENSORS-1:0]   samples,
  input  logic                                        out_stall,
  output logic                                        out_valid,
  output logic [lfpd_pkg::SPD_W-1:0]                  left_speed,
  output logic [lfpd_pkg::SPD_W-1:0]                  right_speed,
  output logic signed [lfpd_pkg::ERR_W-1:0]           line_error,
  output logic [lfpd_pkg::CNTO_W-1:0]                 active_count,
  output lfpd_pkg::stat_t                             stat
);
  import lfpd_pkg::*;

  logic [SENSORS-1:0]      mask_r, mask_nxt;
  logic [CNT_W-1:0]        cnt;
  logic [POS_W-1:0]        pos_sum;
  logic                    take;

  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [LOOP_W-1:0]       loop_r, loop_nxt;
  logic [CNT_W:0]          t1, t2, r1, r2;
  logic                    ge1, ge2;

  logic                    err_ok;
  logic signed [NUM_W+1:0] err_full;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [ERR_W-1:0] prev_r, prev_nxt;
  logic signed [DER_W-1:0] deriv_r, deriv_nxt;
  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic signed [INT_W:0]   isum;

  logic signed [GAIN_W:0]   mul_a;
  logic signed [INT_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  logic [OFF_W-1:0]        off;
  logic [SUM_W-1:0]        base_ext, max_ext, off_ext, lsum, rsum;
  logic [SPD_W-1:0]        lclamp, rclamp;

  logic                    out_valid_r, out_valid_nxt;
  logic [SPD_W-1:0]        left_r, right_r;
  logic signed [ERR_W-1:0] lerr_r;
  logic [CNTO_W-1:0]       cnt_out_r;

  assign take     = in_valid && (op == OP_TAKE);
  assign in_stall = (op != OP_TAKE);

  assign stat.in_avail    = in_valid;
  assign stat.loop_last   = (loop_r == LOOP_W'(DIV_ITER - 1));
  assign stat.out_blocked = out_valid_r && out_stall;

  // Active mask, count and position sum
  always_comb begin
    mask_nxt = mask_r;
    if (take) begin
      for (int k = 0; k < SENSORS; k++) begin
        mask_nxt[k] = (samples[k] < cfg.threshold);
      end
    end
    cnt     = '0;
    pos_sum = '0;
    for (int k = 0; k < SENSORS; k++) begin
      if (mask_r[k]) begin
        cnt     = cnt + CNT_W'(1);
        pos_sum = pos_sum + POS_W'(k + 1);
      end
    end
  end

  // Two restoring quotient bits per cycle; a zero count gives a quotient that is never used
  always_comb begin
    t1  = {rem_r, num_r[NUM_W-1]};
    ge1 = (t1 >= {1'b0, cnt});
    r1  = ge1 ? (t1 - {1'b0, cnt}) : t1;
    t2  = {r1[CNT_W-1:0], num_r[NUM_W-2]};
    ge2 = (t2 >= {1'b0, cnt});
    r2  = ge2 ? (t2 - {1'b0, cnt}) : t2;

    num_nxt  = num_r;
    rem_nxt  = rem_r;
    loop_nxt = loop_r;
    case (op)
      OP_DIV_INIT: begin
        num_nxt  = NUM_W'({pos_sum, {FRAC_W{1'b0}}});
        rem_nxt  = '0;
        loop_nxt = '0;
      end
      OP_DIV_STEP: begin
        num_nxt  = {num_r[NUM_W-3:0], ge1, ge2};
        rem_nxt  = r2[CNT_W-1:0];
        loop_nxt = loop_r + LOOP_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Line error, integral, derivative
  always_comb begin
    err_ok   = (cnt != '0) && (int'(cnt) <= int'(cfg.max_active));
    err_full = (NUM_W + 2)'(CENTRE_Q) - $signed({2'b00, num_r});
    err_nxt  = err_r;
    if (op == OP_ERR) begin
      err_nxt = err_ok ? err_full[ERR_W-1:0] : '0;
    end

    isum = {integ_r[INT_W-1], integ_r}
         + {{(INT_W + 1 - ERR_W){err_r[ERR_W-1]}}, err_r};
    integ_nxt = integ_r;
    deriv_nxt = deriv_r;
    prev_nxt  = prev_r;
    if (op == OP_INTEG) begin
      if (isum[INT_W] != isum[INT_W-1]) begin
        integ_nxt = isum[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}} : {1'b0, {(INT_W - 1){1'b1}}};
      end else begin
        integ_nxt = isum[INT_W-1:0];
      end
      deriv_nxt = {err_r[ERR_W-1], err_r} - {prev_r[ERR_W-1], prev_r};
      prev_nxt  = err_r;
    end
  end

  // Shared multiplier and accumulator
  always_comb begin
    case (op)
      OP_INTEG: begin
        mul_a = $signed({1'b0, cfg.gain_p});
        mul_b = {{(INT_W - ERR_W){err_r[ERR_W-1]}}, err_r};
      end
      OP_MUL_I: begin
        mul_a = $signed({1'b0, cfg.gain_i});
        mul_b = integ_r;
      end
      default: begin
        mul_a = $signed({1'b0, cfg.gain_d});
        mul_b = {{(INT_W - DER_W){deriv_r[DER_W-1]}}, deriv_r};
      end
    endcase
    prod_full = mul_a * mul_b;
    prod_ext  = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    case (op)
      OP_INTEG: prod_nxt = prod_full;
      OP_MUL_I: begin
        prod_nxt = prod_full;
        acc_nxt  = prod_ext;
      end
      OP_MUL_D: begin
        prod_nxt = prod_full;
        acc_nxt  = acc_r + prod_ext;
      end
      OP_ACC:   acc_nxt = acc_r + prod_ext;
      default: begin
      end
    endcase
  end

  // Floor shift by taking the upper bits, then clamp both wheels to 0..max
  always_comb begin
    off      = acc_r[ACC_W-1:GAIN_FRAC];
    base_ext = {{(SUM_W - SPD_W){1'b0}}, cfg.base_speed};
    max_ext  = {{(SUM_W - SPD_W){1'b0}}, cfg.max_speed};
    off_ext  = {off[OFF_W-1], off};
    lsum     = base_ext + off_ext;
    rsum     = base_ext - off_ext;

    if (lsum[SUM_W-1]) begin
      lclamp = '0;
    end else if (lsum > max_ext) begin
      lclamp = cfg.max_speed;
    end else begin
      lclamp = lsum[SPD_W-1:0];
    end
    if (rsum[SUM_W-1]) begin
      rclamp = '0;
    end else if (rsum > max_ext) begin
      rclamp = cfg.max_speed;
    end else begin
      rclamp = rsum[SPD_W-1:0];
    end

    out_valid_nxt = out_valid_r;
    if ((op == OP_EMIT) && !(out_valid_r && out_stall)) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r      <= '0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_r      <= '0;
    end else begin
      loop_r      <= loop_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    err_r   <= err_nxt;
    deriv_r <= deriv_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    // load the result only when the output slot is free
    if ((op == OP_EMIT) && !(out_valid_r && out_stall)) begin
      left_r    <= lclamp;
      right_r   <= rclamp;
      lerr_r    <= err_r;
      cnt_out_r <= CNTO_W'(cnt);
    end
  end

  assign out_valid    = out_valid_r;
  assign left_speed   = left_r;
  assign right_speed  = right_r;
  assign line_error   = lerr_r;
  assign active_count = cnt_out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/line_follow_pid_drive.sv =====
// Top level of the line follower PID drive: configuration registers, sequencer
// and datapath. Depends on lfpd_pkg, lfpd_seq and lfpd_dp.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_sample_0 .. in_sample_7
//   out_     output     out_valid/out_stall  left/right speed, line error, count
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// Each item runs these steps in order: take, divider setup, 7 steps of the 2-bit-per-cycle
// divider, error, 3 steps on the shared PID multiplier, final add and result load.
// Reset is synchronous, active low; it restores the register defaults and clears
// the integral and the previous error.
// A result waiting on out_stall holds the program in its last step; no new item
// is taken until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pid_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_0,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_1,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_2,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_3,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_4,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_5,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_6,
  input  logic [lfpd_pkg::SMP_W-1:0]          in_sample_7,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lfpd_pkg::SPD_W-1:0]          out_left_speed,
  output logic [lfpd_pkg::SPD_W-1:0]          out_right_speed,
  output logic signed [lfpd_pkg::ERR_W-1:0]   out_line_error,
  output logic [lfpd_pkg::CNTO_W-1:0]         out_active_count,
  input  logic                                cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lfpd_pkg::*;

  cfg_t                      cfg_r, cfg_nxt;
  sample_t [SENSORS-1:0]     samples;
  op_t                       op;
  stat_t                     stat;

  assign samples = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                    in_sample_3, in_sample_2, in_sample_1, in_sample_0};

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:  cfg_nxt.threshold  = cfg_data[SMP_W-1:0];
        CFG_GAIN_P:     cfg_nxt.gain_p     = cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:     cfg_nxt.gain_i     = cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:     cfg_nxt.gain_d     = cfg_data[GAIN_W-1:0];
        CFG_BASE_SPEED: cfg_nxt.base_speed = cfg_data[SPD_W-1:0];
        CFG_MAX_SPEED:  cfg_nxt.max_speed  = cfg_data[SPD_W-1:0];
        CFG_MAX_ACTIVE: cfg_nxt.max_active = cfg_data[MAXA_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lfpd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  lfpd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .samples      (samples),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .left_speed   (out_left_speed),
    .right_speed  (out_right_speed),
    .line_error   (out_line_error),
    .active_count (out_active_count),
    .stat         (stat)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lfpd_checker.sv =====
// Port-level checker for the line follower PID drive, bound to the top level.
// Depends on lfpd_pkg widths and the macros in line_follow_pid_drive_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "line_follow_pid_drive_assert.svh"

module lfpd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [lfpd_pkg::SPD_W-1:0]          out_left_speed,
  input logic [lfpd_pkg::SPD_W-1:0]          out_right_speed,
  input logic signed [lfpd_pkg::ERR_W-1:0]   out_line_error,
  input logic [lfpd_pkg::CNTO_W-1:0]         out_active_count
);
  import lfpd_pkg::*;

  `LFPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_left_speed) && $stable(out_right_speed) && $stable(out_line_error) && $stable(out_active_count), "result changed while stalled")
  // the program leaves its input step right after taking an item
  `LFPD_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "second item taken back to back")
  `LFPD_ASSERT_NOW(a_no_line_no_err, out_valid && (out_active_count == '0), out_line_error == '0, "error nonzero with no active sensor")
  `LFPD_ASSERT_NOW(a_err_range, out_valid, (out_line_error >= -11'sd896) && (out_line_error <= 11'sd896), "line error out of range")

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (.*);

`default_nettype wire

// ===== tb/pid_drive_checker.sv =====
`timescale 1ns / 1ps
// Checker for the line follower PID drive: watches the item and result channels
// and the register port, predicts each wheel-speed result and compares it.
// Depends on lfpd_pkg for widths, the register layout and the register codes.

module pid_drive_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_0,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_1,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_2,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_3,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_4,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_5,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_6,
  input  logic [lfpd_pkg::SMP_W-1:0]        in_sample_7,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [lfpd_pkg::SPD_W-1:0]        out_left_speed,
  input  logic [lfpd_pkg::SPD_W-1:0]        out_right_speed,
  input  logic signed [lfpd_pkg::ERR_W-1:0] out_line_error,
  input  logic [lfpd_pkg::CNTO_W-1:0]       out_active_count,
  input  logic                              cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int unsigned                       pending_results,
  output int unsigned                       mismatch_count
);
  import lfpd_pkg::*;

  typedef struct packed {
    logic [SPD_W-1:0]         left;
    logic [SPD_W-1:0]         right;
    logic signed [ERR_W-1:0]  err;
    logic [CNTO_W-1:0]        count;
  } drive_result_t;

  localparam int LINE_CENTRE = (SENSORS + 1) * 128;

  cfg_t          regs;
  int            integ_sum;
  int            prev_err;
  drive_result_t drive_queue[$];

  function automatic logic [SPD_W-1:0] clamp_wheel(input longint v);
    if (v > longint'(regs.max_speed)) v = longint'(regs.max_speed);
    if (v < 0) v = 0;
    return SPD_W'(v);
  endfunction

  // Advance the PID state by one item and return the wheel drive it causes.
  function automatic drive_result_t predict_drive(input logic [SENSORS-1:0][SMP_W-1:0] raw);
    drive_result_t r;
    int unsigned   cnt;
    int unsigned   possum;
    int            err;
    longint        integ;
    longint        deriv;
    longint        acc;
    longint        offset;
    cnt = 0;
    possum = 0;
    err = 0;
    for (int k = 0; k < SENSORS; k++) begin
      if (raw[k] < regs.threshold) begin
        cnt++;
        possum += k + 1;
      end
    end
    if (cnt >= 1 && cnt <= regs.max_active) begin
      err = LINE_CENTRE - int'((possum * 256) / cnt);
    end
    integ = longint'(integ_sum) + err;
    if (integ > longint'(32'sh7FFF_FFFF)) integ = longint'(32'sh7FFF_FFFF);
    if (integ < -longint'(64'sd2147483648)) integ = -longint'(64'sd2147483648);
    integ_sum = int'(integ);
    deriv = longint'(err) - longint'(prev_err);
    prev_err = err;
    acc = longint'(regs.gain_p) * err + longint'(regs.gain_i) * integ
        + longint'(regs.gain_d) * deriv;
    // arithmetic shift rounds toward minus infinity
    offset = acc >>> 12;
    r.left  = clamp_wheel(longint'(regs.base_speed) + offset);
    r.right = clamp_wheel(longint'(regs.base_speed) - offset);
    r.err   = ERR_W'(err);
    r.count = CNTO_W'(cnt);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    drive_result_t want;
    if (!rst_n) begin
      regs.threshold  = SMP_W'(800);
      regs.gain_p     = GAIN_W'(16384);
      regs.gain_i     = GAIN_W'(4);
      regs.gain_d     = GAIN_W'(819);
      regs.base_speed = SPD_W'(2560);
      regs.max_speed  = SPD_W'(5120);
      regs.max_active = MAXA_W'(3);
      integ_sum = 0;
      prev_err  = 0;
      drive_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD:  regs.threshold  = cfg_data[SMP_W-1:0];
          CFG_GAIN_P:     regs.gain_p     = cfg_data;
          CFG_GAIN_I:     regs.gain_i     = cfg_data;
          CFG_GAIN_D:     regs.gain_d     = cfg_data;
          CFG_BASE_SPEED: regs.base_speed = cfg_data;
          CFG_MAX_SPEED:  regs.max_speed  = cfg_data;
          CFG_MAX_ACTIVE: regs.max_active = cfg_data[MAXA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        drive_queue.push_back(predict_drive({in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                                             in_sample_3, in_sample_2, in_sample_1, in_sample_0}));
      end
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          $error("result item arrived with no item pending");
          mismatch_count++;
        end else begin
          want = drive_queue.pop_front();
          if (want.left !== out_left_speed) begin
            $error("left_speed expected %0d got %0d", want.left, out_left_speed);
            mismatch_count++;
          end
          if (want.right !== out_right_speed) begin
            $error("right_speed expected %0d got %0d", want.right, out_right_speed);
            mismatch_count++;
          end
          if (want.err !== out_line_error) begin
            $error("line_error expected %0d got %0d", $signed(want.err), $signed(out_line_error));
            mismatch_count++;
          end
          if (want.count !== out_active_count) begin
            $error("active_count expected %0d got %0d", want.count, out_active_count);
            mismatch_count++;
          end
        end
      end
    end
    pending_results = drive_queue.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the line follower PID drive testbench: clock, reset, sensor items,
// register settings and back-pressure. Depends on lfpd_pkg, the block and
// pid_drive_checker, which predicts and compares every result item.

module testbench;
  import lfpd_pkg::*;

  localparam int LIMIT       = 1000000;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int FIRST_ITEMS = 130;
  localparam int DIRECTED    = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SMP_W-1:0]         in_sample_0 = '0;
  logic [SMP_W-1:0]         in_sample_1 = '0;
  logic [SMP_W-1:0]         in_sample_2 = '0;
  logic [SMP_W-1:0]         in_sample_3 = '0;
  logic [SMP_W-1:0]         in_sample_4 = '0;
  logic [SMP_W-1:0]         in_sample_5 = '0;
  logic [SMP_W-1:0]         in_sample_6 = '0;
  logic [SMP_W-1:0]         in_sample_7 = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [SPD_W-1:0]         out_left_speed;
  logic [SPD_W-1:0]         out_right_speed;
  logic signed [ERR_W-1:0]  out_line_error;
  logic [CNTO_W-1:0]        out_active_count;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_out = 1'b0;
  int          stall_left = 0;
  int          cur_threshold = 800;
  sample_t     smp[SENSORS];

  always #6 clk = ~clk;

  line_follow_pid_drive dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_0      (in_sample_0),
    .in_sample_1      (in_sample_1),
    .in_sample_2      (in_sample_2),
    .in_sample_3      (in_sample_3),
    .in_sample_4      (in_sample_4),
    .in_sample_5      (in_sample_5),
    .in_sample_6      (in_sample_6),
    .in_sample_7      (in_sample_7),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_speed   (out_left_speed),
    .out_right_speed  (out_right_speed),
    .out_line_error   (out_line_error),
    .out_active_count (out_active_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  pid_drive_checker drive_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_0      (in_sample_0),
    .in_sample_1      (in_sample_1),
    .in_sample_2      (in_sample_2),
    .in_sample_3      (in_sample_3),
    .in_sample_4      (in_sample_4),
    .in_sample_5      (in_sample_5),
    .in_sample_6      (in_sample_6),
    .in_sample_7      (in_sample_7),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_speed   (out_left_speed),
    .out_right_speed  (out_right_speed),
    .out_line_error   (out_line_error),
    .out_active_count (out_active_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pending_results  (pending_results),
    .mismatch_count   (mismatch_count)
  );

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer smp as one item and hold it until accepted; returns at the accept edge.
  task automatic send_item();
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_0 <= smp[0];
    in_sample_1 <= smp[1];
    in_sample_2 <= smp[2];
    in_sample_3 <= smp[3];
    in_sample_4 <= smp[4];
    in_sample_5 <= smp[5];
    in_sample_6 <= smp[6];
    in_sample_7 <= smp[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result item is out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending_results == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: random stalls, or one long hold-off counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [SENSORS-1:0] mask;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    int line_pos;
    int width;
    int items;
    bit near_thr;
    line_pos = 3;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = -1; p < PHASES; p++) begin
      if (p >= 0) begin
        wait_drained();
        case (p)
          0: begin
            cur_threshold = 0;
            cfg_write(CFG_THRESHOLD, 16'd0);
            cfg_write(CFG_GAIN_P, 16'd0);
            cfg_write(CFG_GAIN_I, 16'd0);
            cfg_write(CFG_UNUSED, 16'hFFFF);
            cfg_write(CFG_GAIN_D, 16'd0);
            cfg_write(CFG_BASE_SPEED, 16'd0);
            cfg_write(CFG_MAX_SPEED, 16'd0);
            cfg_write(CFG_MAX_ACTIVE, 16'd0);
          end
          1: begin
            cur_threshold = 4095;
            cfg_write(CFG_THRESHOLD, 16'd4095);
            cfg_write(CFG_GAIN_P, 16'hFFFF);
            cfg_write(CFG_GAIN_I, 16'hFFFF);
            cfg_write(CFG_UNUSED, 16'h0000);
            cfg_write(CFG_GAIN_D, 16'hFFFF);
            cfg_write(CFG_BASE_SPEED, 16'hFFFF);
            cfg_write(CFG_MAX_SPEED, 16'hFFFF);
            cfg_write(CFG_MAX_ACTIVE, 16'd8);
          end
          2: begin
            cur_threshold = 800;
            cfg_write(CFG_THRESHOLD, 16'd800);
            cfg_write(CFG_GAIN_P, 16'd16384);
            cfg_write(CFG_GAIN_I, 16'd4);
            cfg_write(CFG_GAIN_D, 16'd819);
            cfg_write(CFG_BASE_SPEED, 16'd2560);
            cfg_write(CFG_MAX_SPEED, 16'd0);
            cfg_write(CFG_MAX_ACTIVE, 16'd3);
          end
          3: begin
            cur_threshold = 2048;
            cfg_write(CFG_THRESHOLD, 16'd2048);
            cfg_write(CFG_GAIN_P, 16'd4096);
            cfg_write(CFG_GAIN_I, 16'd64);
            cfg_write(CFG_GAIN_D, 16'd2048);
            cfg_write(CFG_BASE_SPEED, 16'd32768);
            cfg_write(CFG_MAX_SPEED, 16'hFFFF);
            cfg_write(CFG_MAX_ACTIVE, 16'd8);
          end
          default: begin
            cur_threshold = $urandom_range(100, 4000);
            cfg_write(CFG_THRESHOLD, CFG_DATA_W'(cur_threshold));
            cfg_write(CFG_GAIN_P, ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom)
                                                               : CFG_DATA_W'($urandom_range(0, 8191)));
            cfg_write(CFG_GAIN_I, ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom)
                                                               : CFG_DATA_W'($urandom_range(0, 255)));
            cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
            cfg_write(CFG_GAIN_D, ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom)
                                                               : CFG_DATA_W'($urandom_range(0, 8191)));
            cfg_write(CFG_BASE_SPEED, ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom)
                                                                   : CFG_DATA_W'($urandom_range(0, 8000)));
            cfg_write(CFG_MAX_SPEED, CFG_DATA_W'($urandom));
            cfg_write(CFG_MAX_ACTIVE, CFG_DATA_W'($urandom_range(0, 8)));
          end
        endcase
        @(posedge clk);
      end

      quiet = (p >= 0) && ((p % 4 == 3) || (p == 5));
      // fill the block while the receiver holds off
      if (p == 5) hold_out = 1'b1;

      if (p < 0) begin
        // reset settings: no line, all on, each position, threshold boundary, truncation
        for (int d = 0; d < DIRECTED; d++) begin
          lo = 0;
          hi = 4095;
          case (d)
            0:       mask = 8'h00;
            1:       mask = 8'hFF;
            10: begin
              mask = 8'b0001_1000;
              lo = 799;
              hi = 800;
            end
            11:      mask = 8'h07;
            12:      mask = 8'hE0;
            13:      mask = 8'h81;
            14:      mask = 8'h0F;
            15:      mask = 8'h03;
            16:      mask = 8'hC0;
            17:      mask = 8'b1000_0101;
            18: begin
              mask = 8'h00;
              hi = 800;
            end
            19: begin
              mask = 8'hFF;
              lo = 799;
            end
            default: mask = 8'h01 << (d - 2);
          endcase
          for (int k = 0; k < SENSORS; k++) smp[k] = mask[k] ? SMP_W'(lo) : SMP_W'(hi);
          send_item();
        end
      end

      items = (p < 0) ? FIRST_ITEMS : PHASE_ITEMS;
      for (int j = 0; j < items; j++) begin
        if (p >= 0 && p % 2 == 1 && j == items / 2) begin
          wait_drained();
        end
        if ($urandom_range(0, 9) < 7) begin
          // a line under a few neighboring sensors, drifting across the array
          line_pos += int'($urandom_range(0, 2)) - 1;
          if (line_pos < 0) line_pos = 0;
          if (line_pos > SENSORS - 1) line_pos = SENSORS - 1;
          width = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(0, 8);
          mask = '0;
          for (int k = 0; k < width; k++) begin
            if (line_pos + k < SENSORS) mask[line_pos + k] = 1'b1;
          end
          near_thr = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < SENSORS; k++) begin
            if (mask[k]) begin
              if (near_thr) smp[k] = SMP_W'(cur_threshold - 1);
              else if (cur_threshold == 0) smp[k] = '0;
              else smp[k] = SMP_W'($urandom_range(0, cur_threshold - 1));
            end else begin
              smp[k] = near_thr ? SMP_W'(cur_threshold) : SMP_W'($urandom_range(cur_threshold, 4095));
            end
          end
        end else begin
          for (int k = 0; k < SENSORS; k++) smp[k] = SMP_W'($urandom_range(0, 4095));
        end
        send_item();
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
